// ===== sv/shortest_job_first_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// Shortest-job-first scheduler assertion macros
// Property wrappers shared by the files that carry concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_JOB_FIRST_SCHEDULER_DEFINES_SVH
`define SHORTEST_JOB_FIRST_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define SJF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sjf check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is active.
`define SJF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sjf check failed: next-cycle implication");

`endif

// ===== sv/sjf_pkg.sv =====
// ----------------------------------------------------------------------------
// Shortest-job-first scheduler package
// Sizes, field widths and shared types for the scheduler and its divider.
// ----------------------------------------------------------------------------
package sjf_pkg;

	localparam int MAX_JOBS   = 32;
	localparam int BURST_BITS = 16;

	localparam int IDX_W     = $clog2(MAX_JOBS);
	localparam int CNT_W     = $clog2(MAX_JOBS + 1);
	localparam int ELAPSED_W = BURST_BITS + IDX_W;
	localparam int TOT_W     = ELAPSED_W + IDX_W;
	localparam int FRAC_W    = 8;
	localparam int DVD_W     = TOT_W + FRAC_W;
	localparam int STEP_W    = $clog2(DVD_W + 1);

	// Stream field widths.
	localparam int BURST_IN_W  = 16;
	localparam int IN_DATA_W   = 16;
	localparam int JOB_INDEX_W = 5;
	localparam int JOB_BURST_W = 16;
	localparam int WAIT_W      = 21;
	localparam int AVG_W       = 29;
	localparam int OUT_FIELD_W = JOB_INDEX_W + JOB_BURST_W + 2 * WAIT_W + 2 * AVG_W;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== sv/sjf_div.sv =====
// ----------------------------------------------------------------------------
// Shortest-job-first scheduler divider
// Restoring divider, one quotient bit per cycle, for the average times.
// ----------------------------------------------------------------------------
module sjf_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sjf_pkg::DVD_W-1:0] dividend,
	input  logic [sjf_pkg::CNT_W-1:0] divisor,
	output logic [sjf_pkg::DVD_W-1:0] quotient,
	output sjf_pkg::div_stat_t        stat
);
	import sjf_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0]  quo_q;
	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W:0]    shifted;
	logic              fits;
	logic [CNT_W:0]    rem_nxt;

	// Remainder stays below the divisor, so its low bits carry all of it.
	assign shifted = {rem_q[CNT_W-1:0], quo_q[DVD_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign rem_nxt = fits ? (shifted - {1'b0, dvs_q}) : shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= rem_nxt;
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== sv/shortest_job_first_scheduler.sv =====
// ----------------------------------------------------------------------------
// Shortest-job-first scheduler
// Loads a set of burst times, then emits them in shortest-first order with
// waiting and turnaround times and the set's mean times.
// ----------------------------------------------------------------------------
// Loading takes one burst request per cycle into a 32-entry store; the request
// with tlast closes the set, zero bursts are skipped and bursts past capacity
// are dropped and flagged in tuser on every result. The block then stops
// taking requests. Each result comes from a scan of the store through its
// single registered read port, one entry per cycle. Before the final result
// (tlast) one shared serial divider runs twice, for the mean waiting and
// turnaround times. After the final result is taken the block is cleared
// and accepts the next set.
module shortest_job_first_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata: burst[15:0]
	input  logic [sjf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// tdata: job_index[4:0], job_burst[20:5], waiting[41:21], turnaround[62:42],
	//        avg_waiting[91:63], avg_turnaround[120:92], zero pad[127:121]
	output logic [sjf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast,
	// tuser: overflow[0]
	output logic                           m_axis_tuser
);
	import sjf_pkg::*;

	localparam logic [2:0] ST_LOAD      = 3'd0;
	localparam logic [2:0] ST_SCAN      = 3'd1;
	localparam logic [2:0] ST_PICK      = 3'd2;
	localparam logic [2:0] ST_DIVW_GO   = 3'd3;
	localparam logic [2:0] ST_DIVW_WAIT = 3'd4;
	localparam logic [2:0] ST_DIVT_GO   = 3'd5;
	localparam logic [2:0] ST_DIVT_WAIT = 3'd6;
	localparam logic [2:0] ST_OUT       = 3'd7;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      job_cnt_q;
	logic [CNT_W-1:0]      picks_q;
	logic [CNT_W-1:0]      scan_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic [TOT_W-1:0]      wait_tot_q;
	logic [TOT_W-1:0]      turn_tot_q;
	logic                  dropped_q;
	logic [MAX_JOBS-1:0]   done_q;
	logic                  cmp_vld_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;
	logic                  best_vld_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [BURST_BITS-1:0] best_burst_q;
	logic                  out_final_q;

	logic [BURST_BITS-1:0] burst_store_q [MAX_JOBS];
	logic [BURST_BITS-1:0] rd_data_q;
	logic [IDX_W-1:0]      rd_addr;

	logic [JOB_INDEX_W-1:0] out_idx_q;
	logic [JOB_BURST_W-1:0] out_burst_q;
	logic [WAIT_W-1:0]      out_wait_q;
	logic [WAIT_W-1:0]      out_turn_q;
	logic [AVG_W-1:0]       out_avgw_q;
	logic [AVG_W-1:0]       out_avgt_q;

	logic [BURST_BITS-1:0] in_burst;
	logic                  in_acc;
	logic                  in_store;
	logic                  in_drop;
	logic [CNT_W-1:0]      cnt_nxt;
	logic [ELAPSED_W-1:0]  turn;
	logic [TOT_W-1:0]      wait_tot_nxt;
	logic                  last_pick;
	logic                  out_acc;
	logic                  take_cmp;

	logic                  div_start;
	logic [DVD_W-1:0]      div_dividend;
	logic [DVD_W-1:0]      div_quotient;
	div_stat_t             div_stat;

	assign in_burst  = s_axis_tdata[BURST_BITS-1:0];
	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign in_store  = in_acc && (in_burst != '0) && (job_cnt_q < CNT_W'(MAX_JOBS));
	assign in_drop   = in_acc && (in_burst != '0) && (job_cnt_q >= CNT_W'(MAX_JOBS));
	assign cnt_nxt   = in_store ? (job_cnt_q + CNT_W'(1)) : job_cnt_q;

	assign turn         = elapsed_q + ELAPSED_W'(best_burst_q);
	assign wait_tot_nxt = wait_tot_q + TOT_W'(elapsed_q);
	assign last_pick    = (picks_q + CNT_W'(1)) == job_cnt_q;

	assign m_axis_tvalid = (state_q == ST_OUT);
	assign out_acc       = m_axis_tvalid && m_axis_tready;

	assign rd_addr  = scan_q[IDX_W-1:0];
	assign take_cmp = cmp_vld_s1 && !done_q[cmp_idx_s1] &&
		(!best_vld_q || (rd_data_q < best_burst_q));

	assign div_start    = (state_q == ST_DIVW_GO) || (state_q == ST_DIVT_GO);
	assign div_dividend = (state_q == ST_DIVW_GO) ? {wait_tot_q, FRAC_W'(0)}
		: {turn_tot_q, FRAC_W'(0)};

	sjf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (job_cnt_q),
		.quotient (div_quotient),
		.stat     (div_stat)
	);

	always_ff @(posedge clk) begin
		if (in_store) begin
			burst_store_q[job_cnt_q[IDX_W-1:0]] <= in_burst;
		end
		rd_data_q <= burst_store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			job_cnt_q   <= '0;
			picks_q     <= '0;
			scan_q      <= '0;
			elapsed_q   <= '0;
			wait_tot_q  <= '0;
			turn_tot_q  <= '0;
			dropped_q   <= 1'b0;
			done_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			best_vld_q  <= 1'b0;
			out_final_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						job_cnt_q <= cnt_nxt;
						if (in_drop) begin
							dropped_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							if (cnt_nxt == '0) begin
								// empty set: nothing to schedule, clear
								job_cnt_q <= '0;
								dropped_q <= 1'b0;
							end else begin
								state_q    <= ST_SCAN;
								scan_q     <= '0;
								cmp_vld_s1 <= 1'b0;
								best_vld_q <= 1'b0;
							end
						end
					end
				end
				ST_SCAN: begin
					// issue one read per cycle, compare the entry read last cycle
					if (scan_q < job_cnt_q) begin
						cmp_vld_s1 <= 1'b1;
						scan_q     <= scan_q + CNT_W'(1);
					end else begin
						cmp_vld_s1 <= 1'b0;
						if (!cmp_vld_s1) begin
							state_q <= ST_PICK;
						end
					end
					if (take_cmp) begin
						best_vld_q <= 1'b1;
					end
				end
				ST_PICK: begin
					elapsed_q           <= turn;
					wait_tot_q          <= wait_tot_nxt;
					turn_tot_q          <= turn_tot_q + TOT_W'(turn);
					done_q[best_idx_q]  <= 1'b1;
					picks_q             <= picks_q + CNT_W'(1);
					best_vld_q          <= 1'b0;
					scan_q              <= '0;
					out_final_q         <= last_pick;
					state_q             <= last_pick ? ST_DIVW_GO : ST_OUT;
				end
				ST_DIVW_GO: begin
					state_q <= ST_DIVW_WAIT;
				end
				ST_DIVW_WAIT: begin
					if (div_stat.done) begin
						state_q <= ST_DIVT_GO;
					end
				end
				ST_DIVT_GO: begin
					state_q <= ST_DIVT_WAIT;
				end
				ST_DIVT_WAIT: begin
					if (div_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						if (out_final_q) begin
							// schedule complete: return to the cleared state
							state_q     <= ST_LOAD;
							job_cnt_q   <= '0;
							picks_q     <= '0;
							elapsed_q   <= '0;
							wait_tot_q  <= '0;
							turn_tot_q  <= '0;
							dropped_q   <= 1'b0;
							done_q      <= '0;
							out_final_q <= 1'b0;
						end else begin
							state_q    <= ST_SCAN;
							cmp_vld_s1 <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Payload registers: no reset.
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_addr;
		if (state_q == ST_SCAN && take_cmp) begin
			best_idx_q   <= cmp_idx_s1;
			best_burst_q <= rd_data_q;
		end
		if (state_q == ST_PICK) begin
			out_idx_q   <= JOB_INDEX_W'(best_idx_q);
			out_burst_q <= JOB_BURST_W'(best_burst_q);
			out_wait_q  <= WAIT_W'(elapsed_q);
			out_turn_q  <= WAIT_W'(turn);
			out_avgw_q  <= '0;
			out_avgt_q  <= '0;
		end
		if (state_q == ST_DIVW_WAIT && div_stat.done) begin
			out_avgw_q <= div_quotient[AVG_W-1:0];
		end
		if (state_q == ST_DIVT_WAIT && div_stat.done) begin
			out_avgt_q <= div_quotient[AVG_W-1:0];
		end
	end

	assign m_axis_tdata = {OUT_PAD_W'(0), out_avgt_q, out_avgw_q, out_turn_q,
		out_wait_q, out_burst_q, out_idx_q};
	assign m_axis_tlast = out_final_q;
	assign m_axis_tuser = dropped_q;

`include "shortest_job_first_scheduler_defines.svh"

	`SJF_ASSERT_NOW(a_load_no_output, clk, arst_n, s_axis_tready, !m_axis_tvalid)
	`SJF_ASSERT_NOW(a_div_busy_in_wait, clk, arst_n, div_stat.busy,
		(state_q == ST_DIVW_WAIT) || (state_q == ST_DIVT_WAIT))
	`SJF_ASSERT_NOW(a_final_all_picked, clk, arst_n, m_axis_tvalid && m_axis_tlast,
		picks_q == job_cnt_q)
	`SJF_ASSERT_NEXT(a_final_clears, clk, arst_n, out_acc && m_axis_tlast,
		s_axis_tready && (job_cnt_q == '0) && (done_q == '0))

endmodule

// ===== test/tb_shortest_job_first_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest-job-first scheduler testbench
// Loads burst sets through the request stream and checks every scheduled job
// against a local schedule planner: pick order, waiting and turnaround times,
// the mean times on the closing result and the dropped-job flag. A directed
// table comes first, then random sets with random gaps and stalls on both
// streams, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_shortest_job_first_scheduler;
	import sjf_pkg::*;

	localparam int RANDOM_REQUESTS = 400;
	localparam int QUIET_AFTER     = 360;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 150;
	localparam int CYCLE_LIMIT     = 600000;

	typedef struct packed {
		logic [JOB_INDEX_W-1:0] job_index;
		logic [JOB_BURST_W-1:0] job_burst;
		logic [WAIT_W-1:0]      waiting;
		logic [WAIT_W-1:0]      turnaround;
		logic [AVG_W-1:0]       avg_waiting;
		logic [AVG_W-1:0]       avg_turnaround;
		logic                   overflow;
		logic                   final_res;
	} pick_t;

	typedef enum logic [1:0] {CHECK_MODEL, CHECK_TYPED, CHECK_NONE} row_check_t;

	typedef struct {
		logic [15:0] burst;
		logic        last;
		row_check_t  check;
		pick_t       typed;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  m_axis_tuser;

	// planner state
	logic [15:0] stored_burst [MAX_JOBS];
	bit          picked [MAX_JOBS];
	int          loaded;
	bit          jobs_dropped;

	pick_t       planned_picks [$];
	pick_t       expected_picks [$];
	stim_row_t   stim_rows [$];

	int mismatches;
	int picks_checked;
	int requests_sent;
	int sets_closed;
	int overflow_sets;
	int cycle_count;
	bit quiet;
	bit hold_req;
	bit hold_done;

	shortest_job_first_scheduler DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
			cycle_count, expected_picks.size());
		$display("tb: failure");
		$finish;
	end

	function automatic pick_t make_pick(int idx, int burst, int waiting, int turnaround,
			int avg_w, int avg_t, bit ovf, bit fin);
		pick_t p;
		p.job_index      = idx[JOB_INDEX_W-1:0];
		p.job_burst      = burst[JOB_BURST_W-1:0];
		p.waiting        = waiting[WAIT_W-1:0];
		p.turnaround     = turnaround[WAIT_W-1:0];
		p.avg_waiting    = avg_w[AVG_W-1:0];
		p.avg_turnaround = avg_t[AVG_W-1:0];
		p.overflow       = ovf;
		p.final_res      = fin;
		return p;
	endfunction

	// Load one burst; on a closing request, work out the whole schedule.
	function automatic void plan_schedule(logic [15:0] burst, logic last);
		longint unsigned clock_now;
		longint unsigned wait_sum;
		longint unsigned turn_sum;
		longint unsigned turn;
		longint unsigned avg;
		int best;
		pick_t p;
		planned_picks.delete();
		if (burst != 16'd0) begin
			if (loaded < MAX_JOBS) begin
				stored_burst[loaded] = burst;
				loaded++;
			end else begin
				jobs_dropped = 1'b1;
			end
		end
		if (!last)
			return;
		sets_closed++;
		if (jobs_dropped && loaded > 0)
			overflow_sets++;
		clock_now = 0;
		wait_sum  = 0;
		turn_sum  = 0;
		for (int i = 0; i < MAX_JOBS; i++)
			picked[i] = 1'b0;
		for (int k = 0; k < loaded; k++) begin
			best = -1;
			for (int i = 0; i < loaded; i++)
				if (!picked[i] && (best < 0 || stored_burst[i] < stored_burst[best]))
					best = i;
			turn = clock_now + stored_burst[best];
			wait_sum += clock_now;
			turn_sum += turn;
			p.job_index      = best[JOB_INDEX_W-1:0];
			p.job_burst      = stored_burst[best];
			p.waiting        = clock_now[WAIT_W-1:0];
			p.turnaround     = turn[WAIT_W-1:0];
			p.avg_waiting    = '0;
			p.avg_turnaround = '0;
			p.overflow       = jobs_dropped;
			p.final_res      = 1'b0;
			planned_picks.push_back(p);
			picked[best] = 1'b1;
			clock_now = turn;
		end
		if (loaded > 0) begin
			avg = (wait_sum << 8) / loaded;
			planned_picks[loaded-1].avg_waiting = avg[AVG_W-1:0];
			avg = (turn_sum << 8) / loaded;
			planned_picks[loaded-1].avg_turnaround = avg[AVG_W-1:0];
			planned_picks[loaded-1].final_res = 1'b1;
		end
		loaded       = 0;
		jobs_dropped = 1'b0;
	endfunction

	task automatic add_row(logic [15:0] burst, logic last, row_check_t check, pick_t typed);
		stim_row_t row;
		row.burst = burst;
		row.last  = last;
		row.check = check;
		row.typed = typed;
		stim_rows.push_back(row);
	endtask

	// Offer one request, hold it until taken, then queue what it should produce.
	task automatic send_request(logic [15:0] burst, logic last, row_check_t check,
			pick_t typed);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = burst;
		s_axis_tlast  = last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		requests_sent++;
		plan_schedule(burst, last);
		case (check)
			CHECK_MODEL: begin
				foreach (planned_picks[i])
					expected_picks.push_back(planned_picks[i]);
			end
			CHECK_TYPED: expected_picks.push_back(typed);
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		pick_t got;
		pick_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.job_index      = m_axis_tdata[4:0];
			got.job_burst      = m_axis_tdata[20:5];
			got.waiting        = m_axis_tdata[41:21];
			got.turnaround     = m_axis_tdata[62:42];
			got.avg_waiting    = m_axis_tdata[91:63];
			got.avg_turnaround = m_axis_tdata[120:92];
			got.overflow       = m_axis_tuser;
			got.final_res      = m_axis_tlast;
			if (expected_picks.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual index %0d burst %0d",
					$time, got.job_index, got.job_burst);
				mismatches++;
			end else begin
				want = expected_picks.pop_front();
				picks_checked++;
				check_field("job_index", 32'(want.job_index), 32'(got.job_index));
				check_field("job_burst", 32'(want.job_burst), 32'(got.job_burst));
				check_field("waiting", 32'(want.waiting), 32'(got.waiting));
				check_field("turnaround", 32'(want.turnaround), 32'(got.turnaround));
				check_field("avg_waiting", 32'(want.avg_waiting), 32'(got.avg_waiting));
				check_field("avg_turnaround", 32'(want.avg_turnaround),
					32'(got.avg_turnaround));
				check_field("overflow", 32'(want.overflow), 32'(got.overflow));
				check_field("final_res", 32'(want.final_res), 32'(got.final_res));
			end
		end
	end

	// Output side: random stalls, plus one long hold-off while requests keep coming.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 14) - 1) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	initial begin
		int set_no;
		int set_size;
		int r;
		int random_sent;
		bit heavy;
		logic [15:0] b;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		mismatches    = 0;
		picks_checked = 0;
		requests_sent = 0;
		sets_closed   = 0;
		overflow_sets = 0;
		cycle_count   = 0;
		quiet         = 1'b0;
		hold_req      = 1'b0;
		hold_done     = 1'b0;
		loaded        = 0;
		jobs_dropped  = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single job at the top of the range
		add_row(16'hFFFF, 1'b1, CHECK_TYPED, make_pick(0, 65535, 0, 65535, 0, 65535 * 256, 0, 1));
		// zero burst closing an empty set: rejected, nothing comes out
		add_row(16'h0000, 1'b1, CHECK_NONE, '0);
		// single job at the bottom of the range
		add_row(16'h0001, 1'b1, CHECK_TYPED, make_pick(0, 1, 0, 1, 0, 256, 0, 1));
		// leading zero dropped, tie goes to the lower index, zero burst closes the set
		add_row(16'h0000, 1'b0, CHECK_MODEL, '0);
		add_row(16'd5, 1'b0, CHECK_MODEL, '0);
		add_row(16'd5, 1'b0, CHECK_MODEL, '0);
		add_row(16'd3, 1'b0, CHECK_MODEL, '0);
		add_row(16'h0000, 1'b1, CHECK_MODEL, '0);
		// alternating and single-bit patterns
		add_row(16'hAAAA, 1'b0, CHECK_MODEL, '0);
		add_row(16'h5555, 1'b0, CHECK_MODEL, '0);
		add_row(16'h8000, 1'b0, CHECK_MODEL, '0);
		add_row(16'h0001, 1'b1, CHECK_MODEL, '0);
		// tie on the closing request
		add_row(16'd7, 1'b0, CHECK_MODEL, '0);
		add_row(16'd2, 1'b0, CHECK_MODEL, '0);
		add_row(16'd7, 1'b1, CHECK_MODEL, '0);

		foreach (stim_rows[i])
			send_request(stim_rows[i].burst, stim_rows[i].last, stim_rows[i].check,
				stim_rows[i].typed);

		hold_req    = 1'b1;
		random_sent = 0;
		set_no      = 0;
		while (random_sent < RANDOM_REQUESTS) begin
			set_no++;
			quiet = (random_sent >= QUIET_AFTER);
			r = $urandom_range(0, 99);
			if (r < 5) begin
				// noise: an empty set, possibly padded with rejected zeros
				repeat ($urandom_range(0, 3))
					send_request(16'h0000, 1'b0, CHECK_MODEL, '0);
				send_request(16'h0000, 1'b1, CHECK_MODEL, '0);
			end else begin
				heavy = (set_no == 2);
				if (heavy)
					set_size = MAX_JOBS;
				else if (r < 60)
					set_size = $urandom_range(1, 8);
				else if (r < 85)
					set_size = $urandom_range(9, MAX_JOBS - 1);
				else if (r < 93)
					set_size = MAX_JOBS;
				else
					set_size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 8);
				for (int j = 0; j < set_size; j++) begin
					r = $urandom_range(0, 99);
					if (heavy || (r >= 30 && r < 38))
						b = 16'hFFFF;
					else if (r < 8)
						b = 16'h0000;
					else if (r < 30)
						b = 16'($urandom_range(1, 4));
					else if (r < 45)
						b = 16'h0001;
					else
						b = 16'($urandom_range(1, 65535));
					send_request(b, j == set_size - 1, CHECK_MODEL, '0);
				end
			end
			random_sent = requests_sent - stim_rows.size();
		end
		s_axis_tvalid = 1'b0;
		s_axis_tlast  = 1'b0;

		wait (expected_picks.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("summary: %0d requests in %0d sets (%0d with dropped jobs), %0d results checked",
			requests_sent, sets_closed, overflow_sets, picks_checked);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sjf_pkg.sv
sv/sjf_div.sv
sv/shortest_job_first_scheduler.sv
test/tb_shortest_job_first_scheduler.sv
